// ===== rtl/core/weighted_random_server_pick_core_macros.svh =====
// Assertion macros used by the weighted random server pick datapath.
`ifndef WEIGHTED_RANDOM_SERVER_PICK_CORE_MACROS_SVH
`define WEIGHTED_RANDOM_SERVER_PICK_CORE_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define WRSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define WRSP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define WRSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define WRSP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/wrsp_pkg.sv =====
// Package with widths, control word types and the microcode table of the server pick.
`default_nettype none
package wrsp_pkg;

    // Fixed field widths.
    localparam int ADDR_W      = 32;
    localparam int PORT_W      = 16;
    localparam int WIN_W       = 8;
    localparam int RND_W       = 32;
    localparam int IDX_OUT_W   = 4;
    localparam int BIT_W       = $clog2(RND_W);
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 56;

    // Parameter defaults.
    localparam int MAX_SERVERS_DEF = 16;
    localparam int WEIGHT_BITS_DEF = 8;

    // Microcode step addresses.
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] S_LOAD = 3'd0;
    localparam logic [STEP_W-1:0] S_CHK  = 3'd1;
    localparam logic [STEP_W-1:0] S_DIV  = 3'd2;
    localparam logic [STEP_W-1:0] S_RD   = 3'd3;
    localparam logic [STEP_W-1:0] S_CMP  = 3'd4;
    localparam logic [STEP_W-1:0] S_HIT  = 3'd5;
    localparam logic [STEP_W-1:0] S_ZERO = 3'd6;

    // Jump conditions.
    typedef enum logic [2:0] {
        C_ALWAYS   = 3'd0,
        C_ACC_LAST = 3'd1,
        C_TOT_ZERO = 3'd2,
        C_DIV_DONE = 3'd3,
        C_HIT      = 3'd4,
        C_OUT_FREE = 3'd5
    } t_cond;

    // Datapath actions of one step.
    typedef struct packed {
        logic div_init;
        logic div_step;
        logic walk_init;
        logic mem_rd;
        logic walk_acc;
        logic emit_hit;
        logic emit_zero;
    } t_act;

    // Status fed back from the datapath.
    typedef struct packed {
        logic acc_last;
        logic tot_zero;
        logic div_done;
        logic hit;
        logic out_free;
    } t_stat;

    // One control word: actions, condition and both jump targets.
    typedef struct packed {
        logic              in_ready;
        logic              gate;
        t_cond             cond;
        logic [STEP_W-1:0] jmp_t;
        logic [STEP_W-1:0] jmp_f;
        t_act              act;
    } t_ctrl_word;

    // Microcode table. When gate is set the actions fire only if the condition holds.
    function automatic t_ctrl_word ctrl_rom(input logic [STEP_W-1:0] step);
        t_ctrl_word w;
        w = '0;
        unique case (step)
            S_LOAD: begin
                w.in_ready = 1'b1;
                w.cond     = C_ACC_LAST;
                w.jmp_t    = S_CHK;
                w.jmp_f    = S_LOAD;
            end
            S_CHK: begin
                w.cond          = C_TOT_ZERO;
                w.jmp_t         = S_ZERO;
                w.jmp_f         = S_DIV;
                w.act.div_init  = 1'b1;
                w.act.walk_init = 1'b1;
            end
            S_DIV: begin
                w.cond         = C_DIV_DONE;
                w.jmp_t        = S_RD;
                w.jmp_f        = S_DIV;
                w.act.div_step = 1'b1;
            end
            S_RD: begin
                w.cond       = C_ALWAYS;
                w.jmp_t      = S_CMP;
                w.jmp_f      = S_CMP;
                w.act.mem_rd = 1'b1;
            end
            S_CMP: begin
                w.cond         = C_HIT;
                w.jmp_t        = S_HIT;
                w.jmp_f        = S_RD;
                w.act.walk_acc = 1'b1;
            end
            S_HIT: begin
                w.gate         = 1'b1;
                w.cond         = C_OUT_FREE;
                w.jmp_t        = S_LOAD;
                w.jmp_f        = S_HIT;
                w.act.emit_hit = 1'b1;
            end
            S_ZERO: begin
                w.gate          = 1'b1;
                w.cond          = C_OUT_FREE;
                w.jmp_t         = S_LOAD;
                w.jmp_f         = S_ZERO;
                w.act.emit_zero = 1'b1;
            end
            default: begin
                w.cond  = C_ALWAYS;
                w.jmp_t = S_LOAD;
                w.jmp_f = S_LOAD;
            end
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/wrsp_seq.sv =====
// Microcode sequencer: step counter, control table lookup and conditional jumps.
`default_nettype none
module wrsp_seq (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire wrsp_pkg::t_stat i_stat,
    output wrsp_pkg::t_act     o_act,
    output logic               o_in_ready
);
    import wrsp_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_ctrl_word        cw;
    logic              cond_ok;

    // Fetch the control word of the current step.
    assign cw = ctrl_rom(r_step);

    // Evaluate the jump condition.
    always_comb begin
        unique case (cw.cond)
            C_ALWAYS:   cond_ok = 1'b1;
            C_ACC_LAST: cond_ok = i_stat.acc_last;
            C_TOT_ZERO: cond_ok = i_stat.tot_zero;
            C_DIV_DONE: cond_ok = i_stat.div_done;
            C_HIT:      cond_ok = i_stat.hit;
            C_OUT_FREE: cond_ok = i_stat.out_free;
            default:    cond_ok = 1'b1;
        endcase
    end

    // Gated steps only act once their condition holds.
    assign o_act      = (cw.gate && !cond_ok) ? '0 : cw.act;
    assign o_in_ready = cw.in_ready;
    assign n_step     = cond_ok ? cw.jmp_t : cw.jmp_f;

    // Step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_LOAD;
        end else begin
            r_step <= n_step;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/wrsp_dpath.sv =====
// Datapath: entry memory, weight total, bit-serial remainder, cumulative walk and output register.
`default_nettype none
`include "weighted_random_server_pick_core_macros.svh"
module wrsp_dpath #(
    parameter int MAX_SERVERS = wrsp_pkg::MAX_SERVERS_DEF,
    parameter int WEIGHT_BITS = wrsp_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire wrsp_pkg::t_act                   i_act,
    input  wire logic                             i_in_ready,
    input  wire logic                             i_s_tvalid,
    input  wire logic [wrsp_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input  wire logic                             i_s_tlast,
    input  wire logic                             i_m_tready,
    output wrsp_pkg::t_stat                       o_stat,
    output logic                                  o_m_tvalid,
    output logic [wrsp_pkg::OUT_TDATA_W-1:0]      o_m_tdata,
    output logic                                  o_m_tuser
);
    import wrsp_pkg::*;

    localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int CNT_W = $clog2(MAX_SERVERS + 1);
    localparam int MAXW  = (2 ** WEIGHT_BITS) - 1;
    localparam int TOT_W = $clog2(MAX_SERVERS * MAXW + 1);
    localparam int CW_W  = (WEIGHT_BITS > WIN_W) ? WEIGHT_BITS : WIN_W;
    localparam int ENT_W = ADDR_W + PORT_W + WEIGHT_BITS;

    // Input fields.
    logic [ADDR_W-1:0]      in_addr;
    logic [PORT_W-1:0]      in_port;
    logic [CW_W-1:0]        in_w;
    logic [CW_W-1:0]        w_clamp;
    logic [RND_W-1:0]       in_rnd;
    logic                   in_acc;
    logic                   has_room;

    assign in_addr  = i_s_tdata[ADDR_W-1:0];
    assign in_port  = i_s_tdata[ADDR_W+PORT_W-1:ADDR_W];
    assign in_w     = CW_W'(i_s_tdata[ADDR_W+PORT_W+WIN_W-1:ADDR_W+PORT_W]);
    assign in_rnd   = i_s_tdata[IN_TDATA_W-1:ADDR_W+PORT_W+WIN_W];
    assign w_clamp  = (in_w > CW_W'(MAXW)) ? CW_W'(MAXW) : in_w;
    assign in_acc   = i_s_tvalid && i_in_ready;

    // Entry memory and list bookkeeping.
    logic [ENT_W-1:0]       r_mem [MAX_SERVERS];
    logic [CNT_W-1:0]       r_cnt;
    logic [TOT_W-1:0]       r_tot;
    logic [ENT_W-1:0]       r_rd;
    logic [IDX_W-1:0]       r_rd_idx;
    logic [IDX_W-1:0]       r_idx;
    logic                   emit;

    assign has_room = (r_cnt < CNT_W'(MAX_SERVERS));
    assign emit     = i_act.emit_hit || i_act.emit_zero;

    always_ff @(posedge i_clk) begin
        if (in_acc && has_room) begin
            r_mem[r_cnt[IDX_W-1:0]] <= {WEIGHT_BITS'(w_clamp), in_port, in_addr};
        end
        if (i_act.mem_rd) begin
            r_rd     <= r_mem[r_idx];
            r_rd_idx <= r_idx;
        end
    end

    // Count and total are cleared once a selection is emitted.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_tot <= '0;
        end else if (emit) begin
            r_cnt <= '0;
            r_tot <= '0;
        end else if (in_acc && has_room) begin
            r_cnt <= r_cnt + 1'b1;
            r_tot <= r_tot + TOT_W'(w_clamp);
        end
    end

    // Restoring remainder, one dividend bit per step, most significant first.
    logic [RND_W-1:0]       r_sh;
    logic [TOT_W-1:0]       r_rem;
    logic [BIT_W-1:0]       r_bit;
    logic [TOT_W:0]         trial;

    assign trial = {r_rem, r_sh[RND_W-1]};

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sh <= in_rnd;
        end else if (i_act.div_step) begin
            r_sh <= {r_sh[RND_W-2:0], 1'b0};
        end
        if (i_act.div_init) begin
            r_rem <= '0;
            r_bit <= '0;
        end else if (i_act.div_step) begin
            r_rem <= (trial >= {1'b0, r_tot}) ? TOT_W'(trial - {1'b0, r_tot})
                                               : TOT_W'(trial);
            r_bit <= r_bit + 1'b1;
        end
    end

    // Walk of the cumulative weights.
    logic [TOT_W-1:0]       r_acc;
    logic [TOT_W-1:0]       acc_nx;

    assign acc_nx = r_acc + TOT_W'(r_rd[ENT_W-1:ADDR_W+PORT_W]);

    always_ff @(posedge i_clk) begin
        if (i_act.walk_init) begin
            r_acc <= '0;
            r_idx <= '0;
        end else begin
            if (i_act.mem_rd) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_act.walk_acc) begin
                r_acc <= acc_nx;
            end
        end
    end

    // Output register; a new result may load as the previous one is taken.
    logic                   r_ovalid;
    logic [OUT_TDATA_W-1:0] r_odata;
    logic                   r_ofound;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (emit) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_act.emit_hit) begin
            r_odata  <= OUT_TDATA_W'({IDX_OUT_W'(r_rd_idx), r_rd[ADDR_W+PORT_W-1:0]});
            r_ofound <= 1'b1;
        end else if (i_act.emit_zero) begin
            r_odata  <= '0;
            r_ofound <= 1'b0;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ofound;

    // Status for the sequencer.
    assign o_stat.acc_last = in_acc && i_s_tlast;
    assign o_stat.tot_zero = (r_tot == '0);
    assign o_stat.div_done = (r_bit == BIT_W'(RND_W - 1));
    assign o_stat.hit      = (r_rem < acc_nx);
    assign o_stat.out_free = !r_ovalid || i_m_tready;

    // The reduced value must lie inside the total while the walk runs.
    `WRSP_ASSERT_IMP(a_rem_in_range, i_clk, i_rst_n, i_act.walk_acc, r_rem < r_tot)
    // The remainder steps only run over a non-empty total.
    `WRSP_ASSERT_IMP(a_div_nonzero, i_clk, i_rst_n, i_act.div_step, r_tot != '0)
    // A result never overwrites one that is still waiting.
    `WRSP_ASSERT_IMP(a_emit_free, i_clk, i_rst_n, emit, !r_ovalid || i_m_tready)
    // The list is empty again after each selection.
    `WRSP_ASSERT_NXT(a_list_cleared, i_clk, i_rst_n, emit, r_cnt == '0 && r_tot == '0)

endmodule
`default_nettype wire

// ===== rtl/core/weighted_random_server_pick_core.sv =====
// Top level of the weighted random server pick: sequencer and datapath.
//
// Each accepted input transaction loads one server entry (address, port, weight); weights
// above 2^WEIGHT_BITS-1 are saturated and entries beyond MAX_SERVERS are dropped.
// The transaction marked tlast also carries the random value and starts a selection: the
// microcode program reduces the random value modulo the weight total with a bit-serial
// remainder unit (one of the 32 dividend bits per cycle), then walks the entry memory, each
// entry with a registered read, then accumulate and compare, until the cumulative weight
// passes the remainder. No input is accepted from the last transaction until its result
// is loaded into the output register, also while an earlier result still waits there.
// One result transaction follows each tlast input; tuser is the found flag, and address,
// port and index are zero when nothing was found. Results sit in an output register, so
// entries of the next list load while a result still waits to be taken.
`default_nettype none
module weighted_random_server_pick_core #(
    parameter int MAX_SERVERS = wrsp_pkg::MAX_SERVERS_DEF,
    parameter int WEIGHT_BITS = wrsp_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    // entry_address[31:0], entry_port[47:32], entry_weight[55:48], random_value[87:56]
    input  wire logic [wrsp_pkg::IN_TDATA_W-1:0] i_s_tdata,
    input  wire logic                            i_s_tlast,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    // chosen_address[31:0], chosen_port[47:32], chosen_index[51:48], zero fill[55:52]
    output logic [wrsp_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    // found[0]
    output logic                                 o_m_tuser
);
    import wrsp_pkg::*;

    t_act  act;
    t_stat stat;
    logic  in_ready;

    // Control program.
    wrsp_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_stat     (stat),
        .o_act      (act),
        .o_in_ready (in_ready)
    );

    // Storage and arithmetic.
    wrsp_dpath #(
        .MAX_SERVERS (MAX_SERVERS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_act      (act),
        .i_in_ready (in_ready),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_m_tready (i_m_tready),
        .o_stat     (stat),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    assign o_s_tready = in_ready;

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the weighted random server pick core.
`timescale 1ns / 1ps

// Scoreboard: mirrors the loaded server list and predicts the pick made on each tlast entry.
class pick_scoreboard;
    typedef struct {
        logic [wrsp_pkg::ADDR_W-1:0]    address;
        logic [wrsp_pkg::PORT_W-1:0]    port;
        logic [wrsp_pkg::IDX_OUT_W-1:0] index;
        logic                           found;
    } pick_t;

    logic [wrsp_pkg::ADDR_W-1:0] addr_mem   [wrsp_pkg::MAX_SERVERS_DEF];
    logic [wrsp_pkg::PORT_W-1:0] port_mem   [wrsp_pkg::MAX_SERVERS_DEF];
    logic [wrsp_pkg::WIN_W-1:0]  weight_mem [wrsp_pkg::MAX_SERVERS_DEF];
    int unsigned                 n_stored;
    logic [31:0]                 weight_sum;
    pick_t                       pick_q[$];
    int                          errors;
    int                          picks_checked;
    int                          empty_picks;

    function new();
        n_stored      = 0;
        weight_sum    = '0;
        errors        = 0;
        picks_checked = 0;
        empty_picks   = 0;
    endfunction

    function int pending();
        return pick_q.size();
    endfunction

    // Note one accepted input transaction and, on the last entry, queue the expected pick.
    function void note_entry(input logic [31:0] address, input logic [15:0] port,
                             input logic [7:0] weight, input logic last,
                             input logic [31:0] rnd);
        pick_t       p;
        logic [31:0] target;
        logic [31:0] acc;
        int unsigned i;
        // Entries beyond the list capacity are dropped, but a dropped last entry still picks.
        if (n_stored < wrsp_pkg::MAX_SERVERS_DEF) begin
            addr_mem[n_stored]   = address;
            port_mem[n_stored]   = port;
            weight_mem[n_stored] = weight;
            weight_sum           = weight_sum + weight;
            n_stored++;
        end
        if (!last) return;
        p.address = '0;
        p.port    = '0;
        p.index   = '0;
        p.found   = 1'b0;
        // Walk the cumulative weights until the span holding the reduced random value.
        if (weight_sum != 0) begin
            target = rnd % weight_sum;
            acc    = '0;
            for (i = 0; i < n_stored && !p.found; i++) begin
                acc = acc + weight_mem[i];
                if (target < acc) begin
                    p.address = addr_mem[i];
                    p.port    = port_mem[i];
                    p.index   = i[wrsp_pkg::IDX_OUT_W-1:0];
                    p.found   = 1'b1;
                end
            end
        end
        if (!p.found) empty_picks++;
        pick_q.insert(pick_q.size(), p);
        n_stored   = 0;
        weight_sum = '0;
    endfunction

    // Compare one accepted result transaction with the oldest expected pick.
    function void check_pick(input logic [wrsp_pkg::OUT_TDATA_W-1:0] tdata,
                             input logic found);
        pick_t p;
        if (pick_q.size() == 0) begin
            $display("%0t: result with no pick pending: tdata=%h found=%b", $time, tdata, found);
            errors++;
            return;
        end
        p = pick_q.pop_front();
        picks_checked++;
        if (tdata[31:0] !== p.address) begin
            $display("%0t: chosen_address expected %h, got %h", $time, p.address, tdata[31:0]);
            errors++;
        end
        if (tdata[47:32] !== p.port) begin
            $display("%0t: chosen_port expected %h, got %h", $time, p.port, tdata[47:32]);
            errors++;
        end
        if (tdata[51:48] !== p.index) begin
            $display("%0t: chosen_index expected %0d, got %0d", $time, p.index, tdata[51:48]);
            errors++;
        end
        if (found !== p.found) begin
            $display("%0t: found expected %b, got %b", $time, p.found, found);
            errors++;
        end
    endfunction
endclass

module tb;
    localparam int TARGET_ITEMS = 1950;

    logic                            i_clk      = 1'b0;
    logic                            i_rst_n    = 1'b0;
    logic                            i_s_tvalid = 1'b0;
    logic                            o_s_tready;
    logic [wrsp_pkg::IN_TDATA_W-1:0] i_s_tdata  = '0;
    logic                            i_s_tlast  = 1'b0;
    logic                            o_m_tvalid;
    logic                            i_m_tready = 1'b0;
    logic [wrsp_pkg::OUT_TDATA_W-1:0] o_m_tdata;
    logic                            o_m_tuser;

    pick_scoreboard board = new();
    bit             no_idle = 1'b0;
    int             stall_left = 0;
    int             items_sent = 0;
    int             lists_sent = 0;
    int             overflow_lists = 0;
    int             list_len = 0;

    weighted_random_server_pick_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #10 i_clk = ~i_clk;

    // Result side: check each accepted transaction, then hold tready low for a random stall.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left = 0;
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                board.check_pick(o_m_tdata, o_m_tuser);
                stall_left = no_idle ? 0 : $urandom_range(0, 4);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            i_m_tready <= (stall_left == 0);
        end
    end

    // Offer one server entry after a random gap and return at the edge that accepts it.
    task automatic send_entry(input logic [31:0] address, input logic [15:0] port,
                              input logic [7:0] weight, input logic last,
                              input logic [31:0] rnd);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {rnd, weight, port, address};
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        board.note_entry(address, port, weight, last, rnd);
        items_sent++;
        list_len++;
        if (last) begin
            lists_sent++;
            if (list_len > wrsp_pkg::MAX_SERVERS_DEF) overflow_lists++;
            list_len = 0;
        end
    endtask

    // Load a list of n random entries; the weight style varies per list and the random value per entry.
    task automatic send_list(input int n);
        int          wmode;
        int          rmode;
        logic [7:0]  weight;
        logic [31:0] rnd;
        wmode = $urandom_range(0, 19);
        for (int i = 0; i < n; i++) begin
            if (wmode < 10)      weight = 8'($urandom_range(0, 255));
            else if (wmode < 16) weight = 8'($urandom_range(0, 3));
            else if (wmode < 18) weight = 8'h00;
            else                 weight = 8'hFF;
            rmode = $urandom_range(0, 19);
            if (rmode == 0)      rnd = 32'h0;
            else if (rmode == 1) rnd = 32'hFFFF_FFFF;
            else                 rnd = $urandom;
            send_entry($urandom, 16'($urandom), weight, i == n - 1, rnd);
        end
    endtask

    // Stop offering entries until every expected pick has been taken.
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        int  n;
        int  r;
        bit  paused;
        paused = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed lists: all-ones fields, a zero total, a zero weight skipped over,
        // all-zero fields with full weights, and an overflowing list whose dropped
        // last entry still triggers the pick of the sixteenth stored entry.
        send_entry(32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 1'b1, 32'hFFFF_FFFF);
        send_entry(32'h0000_0000, 16'h0000, 8'h00, 1'b1, 32'h0000_0000);
        send_entry(32'h0A00_0001, 16'h0050, 8'h01, 1'b0, $urandom);
        send_entry(32'h0A00_0002, 16'h0051, 8'h00, 1'b0, $urandom);
        send_entry(32'h0A00_0003, 16'h0052, 8'h01, 1'b1, 32'h0000_0001);
        send_entry(32'h0000_0000, 16'h0000, 8'hFF, 1'b0, 32'h0000_0000);
        send_entry(32'h0000_0000, 16'h0000, 8'hFF, 1'b1, 32'h0000_0000);
        for (int i = 0; i < wrsp_pkg::MAX_SERVERS_DEF; i++)
            send_entry(32'(32'hC0A8_0000 + i), 16'(16'h1F90 + i), 8'h01, 1'b0, $urandom);
        send_entry(32'hDEAD_BEEF, 16'hBEEF, 8'hFF, 1'b1, 32'd15);
        wait_drained();

        // Random lists: mostly short, some long, a few overflowing the store.
        while (items_sent < TARGET_ITEMS) begin
            no_idle = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 99);
            if (r < 70)      n = $urandom_range(1, 6);
            else if (r < 90) n = $urandom_range(7, wrsp_pkg::MAX_SERVERS_DEF);
            else             n = $urandom_range(wrsp_pkg::MAX_SERVERS_DEF + 1,
                                                wrsp_pkg::MAX_SERVERS_DEF + 4);
            send_list(n);
            if (!paused && items_sent >= TARGET_ITEMS / 2) begin
                wait_drained();
                paused = 1'b1;
            end
        end

        wait_drained();
        repeat (100) @(posedge i_clk);
        $display("Loaded %0d server lists from %0d entries, %0d of them overflowing the store.",
                 lists_sent, items_sent, overflow_lists);
        $display("Checked %0d picks, %0d of them with no weight to choose from.",
                 board.picks_checked, board.empty_picks);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #15_000_000;
        $display("Timed out with %0d picks outstanding.", board.pending());
        $display("FAILURE");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/wrsp_pkg.sv
rtl/core/wrsp_seq.sv
rtl/core/wrsp_dpath.sv
rtl/core/weighted_random_server_pick_core.sv
sim/tb.sv
